// ===== src/mcm_pkg.sv =====
package mcm_pkg;

    localparam int COUNT_BITS_DEF = 32;

    // Fixed field widths
    localparam int PIX_BITS   = 8;
    localparam int OCNT_BITS  = 32;
    localparam int RATIO_BITS = 17;
    localparam int FRAC_BITS  = 16;
    localparam int IN_BITS    = 2 * PIX_BITS;
    localparam int OUT_FIELD_BITS = 3 * OCNT_BITS + 3 * RATIO_BITS;
    localparam int OUT_BITS   = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_PAD    = OUT_BITS - OUT_FIELD_BITS;

    localparam int APB_ADDR_BITS = 2;
    localparam int APB_DATA_BITS = 32;

    localparam logic [PIX_BITS-1:0] GT_MOVING     = 8'd255;
    localparam logic [PIX_BITS-1:0] GT_BACKGROUND = 8'd0;
    localparam logic [PIX_BITS-1:0] THRESH_RESET  = 8'd127;

    // Divider step count: one integer bit plus the fraction bits
    localparam int STEP_BITS = 5;
    localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(FRAC_BITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_STEP,
        ST_WAIT
    } state_t;

    typedef enum logic [1:0] {
        RATIO_PREC,
        RATIO_REC,
        RATIO_F1
    } ratio_t;

    typedef struct packed {
        logic   count_en;
        logic   div_load;
        logic   div_step;
        logic   div_first;
        logic   div_last;
        logic   out_load;
        ratio_t ratio;
    } mcm_cmd_t;

endpackage

// ===== src/mask_confusion_metrics_top.sv =====
// Channel   Dir  Handshake          Contents (low bit up)
// s_*       in   s_tvalid/s_tready  tdata: pred_pixel[7:0], gt_pixel[15:8]; tuser: emit_report
// m_*       out  m_tvalid/m_tready  tdata: true_pos, false_pos, false_neg, precision_q16,
//                                   recall_q16, f1_q16, zero pad to 152 bits
// apb       in   psel/penable       register 0 at address 0: pred_threshold[7:0]
//
// Counting runs at one word per clock while no report is in progress.
// A report word runs the shared restoring divider for precision, recall and f1 in turn; the next
// word is accepted once the result word is loaded, later still if m_tready is low.
// Reset clears the three counts and sets the threshold to 127; no clearing pass is needed.
// A waiting result word does not stall pixel counting; only the next report waits for it.
module mask_confusion_metrics_top
    import mcm_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_BITS-1:0]       s_tdata,   // pred_pixel, gt_pixel
    input  logic                     s_tuser,   // emit_report
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_BITS-1:0]      m_tdata,   // true_pos, false_pos, false_neg, precision_q16,
                                                // recall_q16, f1_q16, pad
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    logic [PIX_BITS-1:0] thresh_reg;
    logic                apb_write;
    mcm_cmd_t            cmd;

    assign pready    = 1'b1;
    assign apb_write = psel && penable && pwrite && pready;

    // Single register at address 0; other byte offsets are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thresh_reg <= THRESH_RESET;
        else if (apb_write && (paddr == '0))
            thresh_reg <= pwdata[PIX_BITS-1:0];
    end

    assign prdata = APB_DATA_BITS'(thresh_reg);

    mcm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    mcm_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .pred_pixel     (s_tdata[PIX_BITS-1:0]),
        .gt_pixel       (s_tdata[IN_BITS-1:PIX_BITS]),
        .pred_threshold (thresh_reg),
        .out_data       (m_tdata)
    );

endmodule

// ===== src/mcm_ctrl.sv =====
module mcm_ctrl
    import mcm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    input  logic     s_tuser,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output mcm_cmd_t cmd
);

    state_t                state_reg, state_next;
    ratio_t                ratio_reg, ratio_next;
    logic [STEP_BITS-1:0]  step_reg, step_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ratio_reg     <= RATIO_PREC;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ratio_reg     <= ratio_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ratio_next     = ratio_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !m_tready;

        cmd           = '0;
        cmd.ratio     = ratio_reg;
        cmd.count_en  = accept;
        cmd.div_first = (step_reg == '0);
        cmd.div_last  = (step_reg == STEP_LAST);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && s_tuser)
                begin
                    state_next = ST_LOAD;
                    ratio_next = RATIO_PREC;
                end
            end
            ST_LOAD:
            begin
                cmd.div_load = 1'b1;
                step_next    = '0;
                state_next   = ST_STEP;
            end
            ST_STEP:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    step_next = '0;
                    unique case (ratio_reg)
                        RATIO_PREC:
                        begin
                            ratio_next = RATIO_REC;
                            state_next = ST_LOAD;
                        end
                        RATIO_REC:
                        begin
                            ratio_next = RATIO_F1;
                            state_next = ST_LOAD;
                        end
                        default:
                        begin
                            state_next = ST_WAIT;
                        end
                    endcase
                end
            end
            ST_WAIT:
            begin
                // hold until the output word slot is free
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("pending result word overwritten");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_LAST)
        else $error("divider step count out of range");

    a_report_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser) |=> (state_reg == ST_LOAD && ratio_reg == RATIO_PREC))
        else $error("report word did not start the ratio sequence");

    a_last_ratio: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP && step_reg == STEP_LAST && ratio_reg == RATIO_F1)
        |=> state_reg == ST_WAIT)
        else $error("ratio sequence did not finish");

endmodule

// ===== src/mcm_datapath.sv =====
module mcm_datapath
    import mcm_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  mcm_cmd_t            cmd,
    input  logic [PIX_BITS-1:0] pred_pixel,
    input  logic [PIX_BITS-1:0] gt_pixel,
    input  logic [PIX_BITS-1:0] pred_threshold,
    output logic [OUT_BITS-1:0] out_data
);

    localparam int DW = COUNT_BITS + 2;
    localparam int CW = (COUNT_BITS > OCNT_BITS) ? COUNT_BITS : OCNT_BITS;

    logic [COUNT_BITS-1:0] tp_reg, tp_next;
    logic [COUNT_BITS-1:0] fp_reg, fp_next;
    logic [COUNT_BITS-1:0] fn_reg, fn_next;

    logic [DW-1:0]         den_reg, den_next;
    logic [DW:0]           rem_reg, rem_next;
    logic [FRAC_BITS-1:0]  quo_reg, quo_next;
    logic                  den_zero_reg;
    logic [RATIO_BITS-1:0] prec_reg, rec_reg, f1_reg;
    logic [OUT_BITS-1:0]   out_data_reg;

    logic                  fg;
    logic [DW-1:0]         tp_w, fp_w, fn_w, num_sel, den_sel;
    logic [DW:0]           trial, diff;
    logic                  ge;
    logic [RATIO_BITS-1:0] ratio_val;

    function automatic logic [OCNT_BITS-1:0] clip_count(input logic [COUNT_BITS-1:0] c);
        logic [CW-1:0] ext;
        ext = CW'(c);
        return (ext > CW'({OCNT_BITS{1'b1}})) ? {OCNT_BITS{1'b1}} : ext[OCNT_BITS-1:0];
    endfunction

    // Pixel classification and saturating counts
    always_comb
    begin
        fg      = pred_pixel > pred_threshold;
        tp_next = tp_reg;
        fp_next = fp_reg;
        fn_next = fn_reg;
        if (cmd.count_en)
        begin
            if (gt_pixel == GT_MOVING)
            begin
                if (fg)
                    tp_next = (tp_reg == '1) ? tp_reg : tp_reg + 1'b1;
                else
                    fn_next = (fn_reg == '1) ? fn_reg : fn_reg + 1'b1;
            end
            else if (gt_pixel == GT_BACKGROUND && fg)
            begin
                fp_next = (fp_reg == '1) ? fp_reg : fp_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tp_reg <= '0;
            fp_reg <= '0;
            fn_reg <= '0;
        end
        else
        begin
            tp_reg <= tp_next;
            fp_reg <= fp_next;
            fn_reg <= fn_next;
        end
    end

    // Operand select for the shared restoring divider
    always_comb
    begin
        tp_w = DW'(tp_reg);
        fp_w = DW'(fp_reg);
        fn_w = DW'(fn_reg);
        case (cmd.ratio)
            RATIO_PREC:
            begin
                num_sel = tp_w;
                den_sel = tp_w + fp_w;
            end
            RATIO_REC:
            begin
                num_sel = tp_w;
                den_sel = tp_w + fn_w;
            end
            RATIO_F1:
            begin
                num_sel = tp_w << 1;
                den_sel = (tp_w << 1) + fp_w + fn_w;
            end
            default:
            begin
                num_sel = '0;
                den_sel = '0;
            end
        endcase
    end

    // First step takes the integer bit without a shift
    always_comb
    begin
        trial     = cmd.div_first ? rem_reg : {rem_reg[DW-1:0], 1'b0};
        diff      = trial - {1'b0, den_reg};
        ge        = trial >= {1'b0, den_reg};
        ratio_val = den_zero_reg ? '0 : {quo_reg, ge};
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (cmd.div_load)
        begin
            den_next = den_sel;
            rem_next = {1'b0, num_sel};
            quo_next = '0;
        end
        else if (cmd.div_step)
        begin
            rem_next = ge ? diff : trial;
            quo_next = {quo_reg[FRAC_BITS-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (cmd.div_load)
            den_zero_reg <= (den_sel == '0);
        if (cmd.div_step && cmd.div_last)
        begin
            case (cmd.ratio)
                RATIO_PREC: prec_reg <= ratio_val;
                RATIO_REC:  rec_reg  <= ratio_val;
                default:    f1_reg   <= ratio_val;
            endcase
        end
        if (cmd.out_load)
        begin
            out_data_reg <= {{OUT_PAD{1'b0}}, f1_reg, rec_reg, prec_reg,
                             clip_count(fn_reg), clip_count(fp_reg), clip_count(tp_reg)};
        end
    end

    assign out_data = out_data_reg;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

import mcm_pkg::*;

// Result word layout, low bit up: true_pos, false_pos, false_neg, precision, recall, f1
typedef struct packed {
    logic [RATIO_BITS-1:0] f1;
    logic [RATIO_BITS-1:0] recall;
    logic [RATIO_BITS-1:0] precision;
    logic [OCNT_BITS-1:0]  false_neg;
    logic [OCNT_BITS-1:0]  false_pos;
    logic [OCNT_BITS-1:0]  true_pos;
} metrics_report_t;

class metrics_scoreboard;
    localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_BITS_DEF) - 64'd1;

    logic [PIX_BITS-1:0] threshold;
    logic [63:0]         tp_count;
    logic [63:0]         fp_count;
    logic [63:0]         fn_count;
    metrics_report_t     due_reports[$];
    int                  errors;

    function new();
        threshold = THRESH_RESET;
        tp_count  = '0;
        fp_count  = '0;
        fn_count  = '0;
        errors    = 0;
    endfunction

    function void set_threshold(logic [PIX_BITS-1:0] value);
        threshold = value;
    endfunction

    function logic [63:0] bump(logic [63:0] c);
        return (c >= COUNT_MAX) ? COUNT_MAX : c + 64'd1;
    endfunction

    // floor(65536 * num / den); num never exceeds den
    function logic [RATIO_BITS-1:0] q16(logic [63:0] num, logic [63:0] den);
        if (den == 64'd0)
            return '0;
        return RATIO_BITS'((num << FRAC_BITS) / den);
    endfunction

    function logic [OCNT_BITS-1:0] clamp(logic [63:0] c);
        return (c > 64'hFFFF_FFFF) ? '1 : c[OCNT_BITS-1:0];
    endfunction

    function void count_pixel(logic [PIX_BITS-1:0] pred, logic [PIX_BITS-1:0] gt,
                              logic report);
        metrics_report_t r;
        logic            fg;
        fg = pred > threshold;
        if (gt == GT_MOVING)
        begin
            if (fg)
                tp_count = bump(tp_count);
            else
                fn_count = bump(fn_count);
        end
        else if (gt == GT_BACKGROUND && fg)
            fp_count = bump(fp_count);
        if (report)
        begin
            r.true_pos  = clamp(tp_count);
            r.false_pos = clamp(fp_count);
            r.false_neg = clamp(fn_count);
            r.precision = q16(tp_count, tp_count + fp_count);
            r.recall    = q16(tp_count, tp_count + fn_count);
            r.f1        = q16(2 * tp_count, 2 * tp_count + fp_count + fn_count);
            due_reports.push_back(r);
        end
    endfunction

    function void compare_field(string name, logic [OCNT_BITS-1:0] want,
                                logic [OCNT_BITS-1:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endfunction

    function void check_report(logic [OUT_BITS-1:0] word);
        metrics_report_t got;
        metrics_report_t want;
        got = metrics_report_t'(word[OUT_FIELD_BITS-1:0]);
        if (due_reports.size() == 0)
        begin
            errors++;
            $display("%0t: result word with none expected: %h", $time, word);
            return;
        end
        want = due_reports.pop_front();
        compare_field("true_pos", want.true_pos, got.true_pos);
        compare_field("false_pos", want.false_pos, got.false_pos);
        compare_field("false_neg", want.false_neg, got.false_neg);
        compare_field("precision_q16", want.precision, got.precision);
        compare_field("recall_q16", want.recall, got.recall);
        compare_field("f1_q16", want.f1, got.f1);
    endfunction
endclass

module tb_top;
    localparam int REG_PRED_THRESHOLD = 0;
    localparam int DRAIN_CYCLES       = 60;
    localparam int STALL_LIMIT        = 2000;
    localparam int PHASES             = 8;
    localparam int PHASE_WORDS        = 105;

    logic                     clk;
    logic                     rst_n    = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_BITS-1:0]       s_tdata  = '0;   // pred_pixel, gt_pixel
    logic                     s_tuser  = 1'b0; // emit_report
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_BITS-1:0]      m_tdata;         // true_pos, false_pos, false_neg, precision_q16,
                                               // recall_q16, f1_q16, pad
    logic                     psel     = 1'b0;
    logic                     penable  = 1'b0;
    logic                     pwrite   = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr    = '0;
    logic [APB_DATA_BITS-1:0] pwdata   = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    bit                calm        = 1'b0;
    int                idle_cycles = 0;
    metrics_scoreboard sb          = new();

    mask_confusion_metrics_top uut (.*);

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 7);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.count_pixel(s_tdata[PIX_BITS-1:0], s_tdata[IN_BITS-1:PIX_BITS], s_tuser);
            if (m_tvalid && m_tready)
                sb.check_report(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: stall a random number of cycles before taking each word
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic send_pixel(input logic [PIX_BITS-1:0] pred, input logic [PIX_BITS-1:0] gt,
                              input logic report);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {gt, pred};
        s_tuser  <= report;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_random();
        logic [PIX_BITS-1:0] pred;
        logic [PIX_BITS-1:0] gt;
        int                  pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            gt = GT_MOVING;
        else if (pick < 7)
            gt = GT_BACKGROUND;
        else
            gt = PIX_BITS'($urandom_range(0, 255));
        // land on the threshold now and then; wrap at the ends is harmless
        if ($urandom_range(0, 3) == 0)
            pred = sb.threshold + PIX_BITS'($urandom_range(0, 2)) - 8'd1;
        else
            pred = PIX_BITS'($urandom_range(0, 255));
        send_pixel(pred, gt, $urandom_range(0, 11) == 0);
    endtask

    // Drop valid, wait for every report, then let the divider finish
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.due_reports.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input int index, input logic [APB_DATA_BITS-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= APB_ADDR_BITS'(4 * index);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (index == REG_PRED_THRESHOLD)
            sb.set_threshold(value[PIX_BITS-1:0]);
    endtask

    initial
    begin
        logic [APB_DATA_BITS-1:0] thr;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first report with nothing counted: every denominator is zero; the second counts a true positive
        send_pixel(8'd255, 8'd128, 1'b1);
        send_pixel(8'd255, 8'd255, 1'b1);
        // threshold itself is not foreground; shadow and edge values add nothing
        send_pixel(8'd128, 8'd255, 1'b0);
        send_pixel(8'd127, 8'd255, 1'b0);
        send_pixel(8'd0, 8'd0, 1'b0);
        send_pixel(8'd200, 8'd0, 1'b0);
        send_pixel(8'd255, 8'd1, 1'b0);
        send_pixel(8'd255, 8'd254, 1'b1);
        settle();

        write_reg(REG_PRED_THRESHOLD, 32'd0);
        send_pixel(8'd0, 8'd255, 1'b0);
        send_pixel(8'd1, 8'd255, 1'b0);
        send_pixel(8'd1, 8'd0, 1'b0);
        send_pixel(8'd0, 8'd0, 1'b1);
        settle();

        write_reg(REG_PRED_THRESHOLD, 32'd255);
        send_pixel(8'd255, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd0, 1'b0);
        send_pixel(8'd0, 8'd255, 1'b1);
        settle();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase % 2 == 0)
                thr = $urandom_range(0, 255);
            else
                thr = (phase % 4 == 1) ? 32'd0 : 32'd255;
            write_reg(REG_PRED_THRESHOLD, thr);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (n % 35 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                send_random();
            end
            // close the phase on a report so the final counts are seen
            send_pixel(PIX_BITS'($urandom_range(0, 255)), PIX_BITS'($urandom_range(0, 255)),
                       1'b1);
            settle();
        end

        if (sb.due_reports.size() != 0)
        begin
            sb.errors++;
            $display("%0t: %0d result words never arrived", $time, sb.due_reports.size());
        end
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ===== mask_confusion_metrics_top.f =====
src/mcm_pkg.sv
src/mcm_ctrl.sv
src/mcm_datapath.sv
src/mask_confusion_metrics_top.sv
dv/tb_top.sv
